### src/port_filtered_longest_prefix_match_macros.svh
// Assertion macros used by the top level to check this block.
// Needs clk and rst_n in scope where a macro is used.
`ifndef PORT_FILTERED_LONGEST_PREFIX_MATCH_MACROS_SVH
`define PORT_FILTERED_LONGEST_PREFIX_MATCH_MACROS_SVH

// Same-cycle implication, held off during reset
`define PFLPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define PFLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pflpm_pkg.sv
// Types, codes and helper functions of the port filtered prefix match block.
// No dependencies; used by the interfaces, front, queue, back, top level and testbench.
package pflpm_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int LEN_W       = 6;
  localparam int PORT_W      = 16;
  localparam int ACT_W       = 2;
  localparam int KIND_W      = 2;
  localparam int RSLOT_W     = 2;
  localparam int ESLOT_W     = 3;
  localparam int MAX_SLOTS   = 1 << RSLOT_W;
  localparam int MAX_ENTRIES = 1 << ESLOT_W;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 2;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_WR_PORT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_PREFIX = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE      = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOMATCH = 2'd2;

  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(ADDR_BITS);

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [RSLOT_W-1:0]   request_slot;
    logic [ESLOT_W-1:0]   entry_slot;
    logic [PORT_W-1:0]    port_value;
    logic [ADDR_BITS-1:0] address;
    logic [LEN_W-1:0]     prefix_length;
    logic                 entry_valid;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [RSLOT_W-1:0]   matched_slot;
    logic [LEN_W-1:0]     best_length;
    logic [ADDR_BITS-1:0] probe_address;
    logic [PORT_W-1:0]    probe_port;
    logic                 last;
  } out_item_t;

  // Classified command in the queue between front and back
  typedef struct packed {
    logic [ACT_W-1:0]     op;
    logic                 wen;
    logic [RSLOT_W-1:0]   rslot;
    logic [ESLOT_W-1:0]   eslot;
    logic [PORT_W-1:0]    port;
    logic [ADDR_BITS-1:0] addr;
    logic [LEN_W-1:0]     len;
    logic                 valid;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Network mask of a prefix length; zero length gives an empty mask
  function automatic logic [ADDR_BITS-1:0] len_mask(logic [LEN_W-1:0] len);
    logic [ADDR_BITS-1:0] m;
    if (len >= FULL_LEN) begin
      m = '1;
    end else begin
      m = ~({ADDR_BITS{1'b1}} >> len);
    end
    return m;
  endfunction

  function automatic logic covers(logic [ADDR_BITS-1:0] base, logic [LEN_W-1:0] len,
                                  logic [ADDR_BITS-1:0] addr);
    return ((addr ^ base) & len_mask(len)) == '0;
  endfunction

endpackage

### src/pflpm_if.sv
// Valid/ready channel interfaces for the input items and the results.
// Depends on pflpm_pkg for the payload types.
interface pflpm_in_if;
  logic                 valid;
  logic                 ready;
  pflpm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pflpm_out_if;
  logic                 valid;
  logic                 ready;
  pflpm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/pflpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pflpm_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### src/pflpm_front.sv
// Front end: accepts input beats, drops unused actions, range-checks writes
// and saturates prefix lengths before queueing. Depends on pflpm_pkg, pflpm_if.
module pflpm_front #(
  parameter int REQUEST_SLOTS     = 4,
  parameter int PORTS_PER_SLOT    = 2,
  parameter int PREFIXES_PER_SLOT = 8
) (
  pflpm_in_if.sink               in_ch,
  input  pflpm_pkg::fifo_stat_t  q_stat,
  output logic                   q_push,
  output pflpm_pkg::cmd_t        q_cmd
);
  import pflpm_pkg::*;

  // Only slots and entries that the write fields can address
  localparam int NS = (REQUEST_SLOTS < MAX_SLOTS) ? REQUEST_SLOTS : MAX_SLOTS;
  localparam int NP = (PORTS_PER_SLOT < MAX_ENTRIES) ? PORTS_PER_SLOT : MAX_ENTRIES;
  localparam int NK = (PREFIXES_PER_SLOT < MAX_ENTRIES) ? PREFIXES_PER_SLOT : MAX_ENTRIES;

  logic slot_ok;
  logic port_ok;
  logic pfx_ok;

  assign in_ch.ready = !q_stat.full;

  // Range checks on the write address
  assign slot_ok = {1'b0, in_ch.data.request_slot} < (RSLOT_W + 1)'(NS);
  assign port_ok = {1'b0, in_ch.data.entry_slot} < (ESLOT_W + 1)'(NP);
  assign pfx_ok  = {1'b0, in_ch.data.entry_slot} < (ESLOT_W + 1)'(NK);

  // Action 3 is taken and dropped
  assign q_push = in_ch.valid && !q_stat.full && (in_ch.data.action != ACT_NONE);

  always_comb begin
    q_cmd       = '0;
    q_cmd.op    = in_ch.data.action;
    q_cmd.rslot = in_ch.data.request_slot;
    q_cmd.eslot = in_ch.data.entry_slot;
    q_cmd.port  = in_ch.data.port_value;
    q_cmd.addr  = in_ch.data.address;
    q_cmd.valid = in_ch.data.entry_valid;
    q_cmd.len   = (in_ch.data.prefix_length > FULL_LEN) ? FULL_LEN
                                                        : in_ch.data.prefix_length;
    case (in_ch.data.action)
      ACT_WR_PORT:   q_cmd.wen = slot_ok && port_ok;
      ACT_WR_PREFIX: q_cmd.wen = slot_ok && pfx_ok;
      default:       q_cmd.wen = 1'b0;
    endcase
  end

endmodule

### src/pflpm_queue.sv
// Short command queue between front and back so each side stalls on its own.
// Depends on pflpm_pkg.
module pflpm_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  pflpm_pkg::cmd_t        push_cmd,
  input  logic                   pop,
  output pflpm_pkg::cmd_t        pop_cmd,
  output pflpm_pkg::fifo_stat_t  stat
);
  import pflpm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_cmd    = q_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/pflpm_back.sv
// Back end: holds the port and prefix tables, executes writes and runs the
// two-pass lookup, driving the result register. Depends on pflpm_pkg,
// pflpm_if and pflpm_ram.
module pflpm_back #(
  parameter int REQUEST_SLOTS     = 4,
  parameter int PORTS_PER_SLOT    = 2,
  parameter int PREFIXES_PER_SLOT = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pflpm_pkg::fifo_stat_t  q_stat,
  input  pflpm_pkg::cmd_t        q_cmd,
  output logic                   q_pop,
  pflpm_out_if.source            out_ch
);
  import pflpm_pkg::*;

  localparam int NS = (REQUEST_SLOTS < MAX_SLOTS) ? REQUEST_SLOTS : MAX_SLOTS;
  localparam int NP = (PORTS_PER_SLOT < MAX_ENTRIES) ? PORTS_PER_SLOT : MAX_ENTRIES;
  localparam int NK = (PREFIXES_PER_SLOT < MAX_ENTRIES) ? PREFIXES_PER_SLOT : MAX_ENTRIES;
  localparam int SW = (NS > 1) ? $clog2(NS) : 1;
  localparam int JW = (NP > 1) ? $clog2(NP) : 1;
  localparam int KW = (NK > 1) ? $clog2(NK) : 1;
  localparam int AW = SW + KW;
  localparam int DEPTH = 1 << AW;
  localparam int RAM_W = ADDR_BITS + LEN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BEST = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Tables
  logic              port_v_r   [NS][NP];
  logic [PORT_W-1:0] port_val_r [NS][NP];
  logic              pfx_v_r    [DEPTH];
  logic              port_hit   [NS][NP];
  logic              slot_hit   [NS];

  // Lookup sequencer
  logic [1:0]           state_r, state_nxt;
  logic [ADDR_BITS-1:0] look_addr_r, look_addr_nxt;
  logic [PORT_W-1:0]    look_port_r, look_port_nxt;
  logic                 found_r, found_nxt;
  logic [LEN_W-1:0]     best_r, best_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic                 hold_v_r, hold_v_nxt;
  logic [SW-1:0]        hold_slot_r, hold_slot_nxt;
  logic [SW-1:0]        scan_s_r, scan_s_nxt;
  logic [JW-1:0]        scan_j_r, scan_j_nxt;
  logic [KW-1:0]        scan_k_r, scan_k_nxt;
  logic                 iss_done_r, iss_done_nxt;

  // Read stage behind the prefix RAM
  logic                 p_v_r, p_v_nxt;
  logic                 p_hit_r, p_hit_nxt;
  logic [SW-1:0]        p_s_r, p_s_nxt;
  logic [AW-1:0]        p_idx_r, p_idx_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r;
  out_item_t            out_data;
  logic                 out_load;
  logic                 out_free;

  // RAM and table write controls
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [AW-1:0]        ram_waddr;
  logic [RAM_W-1:0]     ram_wdata;
  logic [RAM_W-1:0]     ram_rdata;
  logic                 pfx_we;
  logic                 port_we;

  logic [ADDR_BITS-1:0] rd_base;
  logic [LEN_W-1:0]     rd_len;
  logic                 rd_cov;
  logic                 best_hit;
  logic                 emit_hit;
  logic                 advance;
  logic                 last_k;
  logic                 last_j;
  logic                 last_s;

  pflpm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_pfx_ram (
    .clk   (clk),
    .we    (pfx_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Port compare of every entry against the probe port
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      slot_hit[s] = 1'b0;
      for (int j = 0; j < NP; j++) begin
        port_hit[s][j] = port_v_r[s][j] && (port_val_r[s][j] == look_port_r);
        slot_hit[s]    = slot_hit[s] | port_hit[s][j];
      end
    end
  end

  // Evaluation of the entry last read from the prefix RAM
  assign rd_base  = ram_rdata[RAM_W-1:LEN_W];
  assign rd_len   = ram_rdata[LEN_W-1:0];
  assign rd_cov   = pfx_v_r[p_idx_r] && covers(rd_base, rd_len, look_addr_r);
  assign best_hit = p_v_r && p_hit_r && rd_cov;
  assign emit_hit = best_hit && (rd_len == best_r);

  assign out_free  = !out_valid_r || out_ch.ready;
  assign ram_waddr = {q_cmd.rslot[SW-1:0], q_cmd.eslot[KW-1:0]};
  assign ram_wdata = {q_cmd.addr, q_cmd.len};
  assign ram_raddr = {scan_s_r, scan_k_r};

  // Scan position wrap points
  assign last_k = (scan_k_r == KW'(NK - 1));
  assign last_j = (state_r == ST_BEST) || (scan_j_r == JW'(NP - 1));
  assign last_s = (scan_s_r == SW'(NS - 1));

  // A held match can only be pushed out when the result register is free
  assign advance = !p_v_r || !(state_r == ST_EMIT && emit_hit && hold_v_r && !out_free);

  always_comb begin
    state_nxt     = state_r;
    look_addr_nxt = look_addr_r;
    look_port_nxt = look_port_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    n_nxt         = n_r;
    hold_v_nxt    = hold_v_r;
    hold_slot_nxt = hold_slot_r;
    scan_s_nxt    = scan_s_r;
    scan_j_nxt    = scan_j_r;
    scan_k_nxt    = scan_k_r;
    iss_done_nxt  = iss_done_r;
    p_v_nxt       = p_v_r;
    p_hit_nxt     = p_hit_r;
    p_s_nxt       = p_s_r;
    p_idx_nxt     = p_idx_r;
    q_pop         = 1'b0;
    ram_re        = 1'b0;
    pfx_we        = 1'b0;
    port_we       = 1'b0;
    out_load      = 1'b0;
    out_data      = '0;

    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          if (q_cmd.op == ACT_LOOKUP) begin
            q_pop         = 1'b1;
            look_addr_nxt = q_cmd.addr;
            look_port_nxt = q_cmd.port;
            found_nxt     = 1'b0;
            best_nxt      = '0;
            n_nxt         = '0;
            hold_v_nxt    = 1'b0;
            scan_s_nxt    = '0;
            scan_j_nxt    = '0;
            scan_k_nxt    = '0;
            iss_done_nxt  = 1'b0;
            p_v_nxt       = 1'b0;
            state_nxt     = ST_BEST;
          end else if (out_free) begin
            // Table write and its acknowledge load in the same cycle
            q_pop                 = 1'b1;
            port_we               = q_cmd.wen && (q_cmd.op == ACT_WR_PORT);
            pfx_we                = q_cmd.wen && (q_cmd.op == ACT_WR_PREFIX);
            out_load              = 1'b1;
            out_data.kind         = KIND_ACK;
            out_data.matched_slot = q_cmd.rslot;
            out_data.last         = 1'b1;
          end
        end
      end

      ST_BEST, ST_EMIT: begin
        // Evaluate the entry in the read stage
        if (state_r == ST_BEST) begin
          if (best_hit) begin
            found_nxt = 1'b1;
            if (rd_len > best_r) begin
              best_nxt = rd_len;
            end
          end
        end else if (emit_hit && advance) begin
          if (hold_v_r) begin
            out_load               = 1'b1;
            out_data.kind          = KIND_MATCH;
            out_data.matched_slot  = RSLOT_W'(hold_slot_r);
            out_data.best_length   = best_r;
            out_data.probe_address = look_addr_r;
            out_data.probe_port    = look_port_r;
          end
          hold_v_nxt    = 1'b1;
          hold_slot_nxt = p_s_r;
          n_nxt         = n_r + CNT_W'(1);
        end

        // Issue the next table read
        if (advance) begin
          p_v_nxt = !iss_done_r;
          if (!iss_done_r) begin
            ram_re    = 1'b1;
            p_hit_nxt = (state_r == ST_BEST) ? slot_hit[scan_s_r]
                                             : port_hit[scan_s_r][scan_j_r];
            p_s_nxt   = scan_s_r;
            p_idx_nxt = {scan_s_r, scan_k_r};
            if (!last_k) begin
              scan_k_nxt = scan_k_r + KW'(1);
            end else begin
              scan_k_nxt = '0;
              if (!last_j) begin
                scan_j_nxt = scan_j_r + JW'(1);
              end else begin
                scan_j_nxt = '0;
                if (!last_s) begin
                  scan_s_nxt = scan_s_r + SW'(1);
                end else begin
                  iss_done_nxt = 1'b1;
                end
              end
            end
          end
        end

        // Pass completion
        if (iss_done_r && !p_v_r) begin
          if (state_r == ST_BEST && found_r) begin
            scan_s_nxt   = '0;
            scan_j_nxt   = '0;
            scan_k_nxt   = '0;
            iss_done_nxt = 1'b0;
            state_nxt    = ST_EMIT;
          end else begin
            state_nxt = ST_FIN;
          end
        end

        // Result cap reached: stop the scan, the held one goes out last
        if (state_r == ST_EMIT && n_nxt == CNT_W'(MAX_RESULTS) && n_r != n_nxt) begin
          p_v_nxt      = 1'b0;
          iss_done_nxt = 1'b1;
          state_nxt    = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_data.probe_address = look_addr_r;
          out_data.probe_port    = look_port_r;
          out_data.last          = 1'b1;
          if (found_r) begin
            out_data.kind         = KIND_MATCH;
            out_data.matched_slot = RSLOT_W'(hold_slot_r);
            out_data.best_length  = best_r;
          end else begin
            out_data.kind = KIND_NOMATCH;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register handshake
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_done_r  <= 1'b0;
      p_v_r       <= 1'b0;
      hold_v_r    <= 1'b0;
      found_r     <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_done_r  <= iss_done_nxt;
      p_v_r       <= p_v_nxt;
      hold_v_r    <= hold_v_nxt;
      found_r     <= found_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    look_addr_r <= look_addr_nxt;
    look_port_r <= look_port_nxt;
    best_r      <= best_nxt;
    hold_slot_r <= hold_slot_nxt;
    scan_s_r    <= scan_s_nxt;
    scan_j_r    <= scan_j_nxt;
    scan_k_r    <= scan_k_nxt;
    p_hit_r     <= p_hit_nxt;
    p_s_r       <= p_s_nxt;
    p_idx_r     <= p_idx_nxt;
    if (out_load) begin
      out_item_r <= out_data;
    end
  end

  // Entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        pfx_v_r[i] <= 1'b0;
      end
      for (int s = 0; s < NS; s++) begin
        for (int j = 0; j < NP; j++) begin
          port_v_r[s][j] <= 1'b0;
        end
      end
    end else begin
      if (pfx_we) begin
        pfx_v_r[ram_waddr] <= q_cmd.valid;
      end
      if (port_we) begin
        port_v_r[q_cmd.rslot[SW-1:0]][q_cmd.eslot[JW-1:0]] <= q_cmd.valid;
      end
    end
  end

  // Port values
  always_ff @(posedge clk) begin
    if (port_we) begin
      port_val_r[q_cmd.rslot[SW-1:0]][q_cmd.eslot[JW-1:0]] <= q_cmd.port;
    end
  end

endmodule

### src/port_filtered_longest_prefix_match.sv
// Port filtered longest prefix match. Write beats fill port entries and IPv4
// prefix entries of the request slots; a lookup beat returns one match result
// per (slot, equal port entry, covering prefix) at the longest covering
// length, in slot, port entry, prefix order, capped at 64 with last on the
// final one, or a single no-match result. Every write returns one
// acknowledge. A lookup reads the prefix RAM one entry per cycle through
// its single read port: a best pass of NS*NK reads and, when something
// matched, an emit pass of NS*NP*NK reads (NS, NP, NK are the slot, port
// and prefix counts reachable by the 2-bit and 3-bit write indexes), on
// top of the queue pop, the read-stage drain after each pass and the final
// result. A write is executed in the back end in the cycle it is popped,
// and a stalled result register holds the emit pass in place. A two-entry
// queue lets the input side keep taking beats while a lookup runs. All table
// entries come out of reset invalid at once; there is no clearing pass.
//
// Top level; depends on pflpm_pkg, pflpm_if, pflpm_front, pflpm_queue,
// pflpm_back and the assertion macros header.
`include "port_filtered_longest_prefix_match_macros.svh"

module port_filtered_longest_prefix_match #(
  parameter int REQUEST_SLOTS     = 4,
  parameter int PORTS_PER_SLOT    = 2,
  parameter int PREFIXES_PER_SLOT = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  pflpm_in_if.sink     in_ch,
  pflpm_out_if.source  out_ch
);
  import pflpm_pkg::*;

  logic       q_push;
  logic       q_pop;
  cmd_t       q_in_cmd;
  cmd_t       q_out_cmd;
  fifo_stat_t q_stat;

  // Accept and classify
  pflpm_front #(
    .REQUEST_SLOTS     (REQUEST_SLOTS),
    .PORTS_PER_SLOT    (PORTS_PER_SLOT),
    .PREFIXES_PER_SLOT (PREFIXES_PER_SLOT)
  ) u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_cmd  (q_in_cmd)
  );

  // Command queue
  pflpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .stat     (q_stat)
  );

  // Tables, lookup and results
  pflpm_back #(
    .REQUEST_SLOTS     (REQUEST_SLOTS),
    .PORTS_PER_SLOT    (PORTS_PER_SLOT),
    .PREFIXES_PER_SLOT (PREFIXES_PER_SLOT)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_cmd  (q_out_cmd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // Checks
  `PFLPM_ASSERT_SAME(a_nomatch_form, out_ch.valid && out_ch.data.kind == KIND_NOMATCH, out_ch.data.last && out_ch.data.best_length == '0 && out_ch.data.matched_slot == '0, "no-match result malformed")
  `PFLPM_ASSERT_SAME(a_ack_form, out_ch.valid && out_ch.data.kind == KIND_ACK, out_ch.data.last && out_ch.data.probe_address == '0 && out_ch.data.probe_port == '0, "write acknowledge malformed")
  `PFLPM_ASSERT_SAME(a_push_room, q_push, !q_stat.full, "queue pushed while full")
  `PFLPM_ASSERT_SAME(a_pop_data, q_pop, !q_stat.empty, "queue popped while empty")

endmodule

### tb/tb_port_filtered_longest_prefix_match.sv
// Self-checking testbench for port_filtered_longest_prefix_match: predicts the
// rule table and every ack, match and no-match beat, and checks them in order.
// Depends on pflpm_pkg, pflpm_if and the block's RTL.
`timescale 1ns / 1ps

module tb_port_filtered_longest_prefix_match;
  import pflpm_pkg::*;

  localparam int NUM_SLOTS = 4;
  localparam int PORTS_PER = 2;
  localparam int PFX_PER   = 8;
  localparam int DRAIN_CYC = 200;

  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] port;
  } port_rule_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] base;
    logic [LEN_W-1:0]     len;
  } pfx_rule_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pflpm_in_if  in_ch();
  pflpm_out_if out_ch();

  port_filtered_longest_prefix_match #(
    .REQUEST_SLOTS    (NUM_SLOTS),
    .PORTS_PER_SLOT   (PORTS_PER),
    .PREFIXES_PER_SLOT(PFX_PER)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow rule table and the results still owed by the block
  port_rule_t port_rules [NUM_SLOTS][PORTS_PER];
  pfx_rule_t  pfx_rules  [NUM_SLOTS][PFX_PER];
  out_item_t  lpm_results_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int n_beats = 0;
  int n_writes = 0;
  int n_lookups = 0;
  int n_match = 0;
  int n_nomatch = 0;
  int n_ack = 0;
  int widest_fanout = 0;

  logic [PORT_W-1:0]    port_pool [3];
  logic [ADDR_BITS-1:0] addr_pool [2];

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      for (int j = 0; j < PORTS_PER; j++) port_rules[s][j] = '0;
      for (int k = 0; k < PFX_PER; k++) pfx_rules[s][k] = '0;
    end
  end

  function automatic logic [ADDR_BITS-1:0] netmask(logic [LEN_W-1:0] len);
    if (len == 0) return '0;
    if (len >= ADDR_BITS) return '1;
    return {ADDR_BITS{1'b1}} << (ADDR_BITS - len);
  endfunction

  function automatic logic rule_hits(pfx_rule_t p, logic [ADDR_BITS-1:0] addr);
    return p.valid && (((addr ^ p.base) & netmask(p.len)) == '0);
  endfunction

  // Update the shadow table for one accepted beat and queue its results
  function automatic void compute_lpm_results(in_item_t b);
    out_item_t r;
    out_item_t batch [$];
    logic found;
    logic [LEN_W-1:0] best;
    logic [LEN_W-1:0] len_sat;
    r = '0;
    found = 1'b0;
    best = '0;
    case (b.action)
      ACT_WR_PORT, ACT_WR_PREFIX: begin
        if (b.action == ACT_WR_PORT) begin
          if (b.entry_slot < PORTS_PER)
            port_rules[b.request_slot][b.entry_slot] = '{b.entry_valid, b.port_value};
        end else if (b.entry_slot < PFX_PER) begin
          len_sat = (b.prefix_length > FULL_LEN) ? FULL_LEN : b.prefix_length;
          pfx_rules[b.request_slot][b.entry_slot] = '{b.entry_valid, b.address, len_sat};
        end
        r.kind = KIND_ACK;
        r.matched_slot = b.request_slot;
        r.last = 1'b1;
        lpm_results_due.push_back(r);
        n_writes++;
      end
      ACT_LOOKUP: begin
        n_lookups++;
        // best pass over slots whose port entries equal the probe port
        for (int s = 0; s < NUM_SLOTS; s++)
          for (int j = 0; j < PORTS_PER; j++)
            if (port_rules[s][j].valid && port_rules[s][j].port == b.port_value)
              for (int k = 0; k < PFX_PER; k++)
                if (rule_hits(pfx_rules[s][k], b.address)) begin
                  found = 1'b1;
                  if (pfx_rules[s][k].len > best) best = pfx_rules[s][k].len;
                end
        r.probe_address = b.address;
        r.probe_port = b.port_value;
        if (!found) begin
          r.kind = KIND_NOMATCH;
          r.last = 1'b1;
          lpm_results_due.push_back(r);
        end else begin
          // emit pass, capped at MAX_RESULTS beats
          r.kind = KIND_MATCH;
          r.best_length = best;
          for (int s = 0; s < NUM_SLOTS; s++)
            for (int j = 0; j < PORTS_PER; j++)
              if (port_rules[s][j].valid && port_rules[s][j].port == b.port_value)
                for (int k = 0; k < PFX_PER; k++)
                  if (batch.size() < MAX_RESULTS
                      && rule_hits(pfx_rules[s][k], b.address)
                      && pfx_rules[s][k].len == best) begin
                    r.matched_slot = s[RSLOT_W-1:0];
                    batch.push_back(r);
                  end
          batch[batch.size()-1].last = 1'b1;
          if (batch.size() > widest_fanout) widest_fanout = batch.size();
          foreach (batch[i]) lpm_results_due.push_back(batch[i]);
        end
      end
      default: ;
    endcase
  endfunction

  // Send one beat at a falling edge; predict it on the edge that takes it
  task automatic send_beat(in_item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    compute_lpm_results(b);
    n_beats++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (lpm_results_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t beat_of(logic [ACT_W-1:0] act, int rslot, int eslot,
                                       logic [PORT_W-1:0] port,
                                       logic [ADDR_BITS-1:0] addr, int len, bit vld);
    in_item_t b;
    b.action = act;
    b.request_slot = rslot[RSLOT_W-1:0];
    b.entry_slot = eslot[ESLOT_W-1:0];
    b.port_value = port;
    b.address = addr;
    b.prefix_length = len[LEN_W-1:0];
    b.entry_valid = vld;
    return b;
  endfunction

  // Receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic note_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  exp kind=%0d slot=%0d len=%0d addr=%h port=%h last=%0d",
               want.kind, want.matched_slot, want.best_length,
               want.probe_address, want.probe_port, want.last);
      $display("  got kind=%0d slot=%0d len=%0d addr=%h port=%h last=%0d",
               got.kind, got.matched_slot, got.best_length,
               got.probe_address, got.probe_port, got.last);
    end
  endtask

  // Result checker, compares each beat with the oldest owed result
  out_item_t mon_got;
  out_item_t mon_want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      mon_got = out_ch.data;
      if (lpm_results_due.size() == 0) begin
        note_mismatch("unexpected result", '0, mon_got);
      end else begin
        mon_want = lpm_results_due.pop_front();
        if (mon_got.kind !== mon_want.kind || mon_got.matched_slot !== mon_want.matched_slot
            || mon_got.best_length !== mon_want.best_length
            || mon_got.probe_address !== mon_want.probe_address
            || mon_got.probe_port !== mon_want.probe_port || mon_got.last !== mon_want.last)
          note_mismatch("result mismatch", mon_want, mon_got);
      end
      case (mon_got.kind)
        KIND_ACK:     n_ack++;
        KIND_MATCH:   n_match++;
        KIND_NOMATCH: n_nomatch++;
        default: ;
      endcase
    end
  end

  // Corner cases: empty table, /0 and /32, overlong length, out-of-range
  // entry, clears, unused action
  task automatic test_directed();
    send_idle_pct = 29;
    recv_idle_pct = 76;
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'h0000, 32'h0000_0000, 0, 0));
    send_beat(beat_of(ACT_LOOKUP, 3, 7, 16'hFFFF, 32'hFFFF_FFFF, 63, 1));
    send_beat(beat_of(ACT_WR_PORT, 0, 0, 16'hFFFF, 32'h0, 0, 1));
    send_beat(beat_of(ACT_WR_PORT, 3, 7, 16'hFFFF, 32'hFFFF_FFFF, 63, 1));
    send_beat(beat_of(ACT_WR_PREFIX, 0, 0, 16'h0, 32'hFFFF_FFFF, 63, 1));
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0));
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'hFFFF, 32'hFFFF_FFFE, 0, 0));
    send_beat(beat_of(ACT_WR_PREFIX, 0, 7, 16'h0, 32'hA5A5_A5A5, 0, 1));
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'hFFFF, 32'h1234_5678, 0, 0));
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0));
    send_beat(beat_of(ACT_WR_PORT, 3, 1, 16'h0000, 32'h0, 0, 1));
    send_beat(beat_of(ACT_WR_PREFIX, 3, 3, 16'h0, 32'h0A00_0000, 8, 1));
    send_beat(beat_of(ACT_WR_PREFIX, 3, 4, 16'h0, 32'h0A0B_0000, 16, 1));
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'h0000, 32'h0A0B_0C0D, 0, 0));
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'h0000, 32'h0AFF_0000, 0, 0));
    send_beat(beat_of(ACT_NONE, 3, 7, 16'hFFFF, 32'hFFFF_FFFF, 63, 1));
    send_beat(beat_of(ACT_WR_PREFIX, 3, 4, 16'h0, 32'h0A0B_0000, 16, 0));
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'h0000, 32'h0A0B_0C0D, 0, 0));
    send_beat(beat_of(ACT_WR_PORT, 0, 0, 16'hFFFF, 32'h0, 0, 0));
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0));
    send_beat(beat_of(ACT_WR_PREFIX, 3, 5, 16'h0, 32'h0000_0000, 32, 1));
    send_beat(beat_of(ACT_LOOKUP, 0, 0, 16'h0000, 32'h0000_0000, 0, 0));
    wait_drained();
  endtask

  // Every slot, port entry and prefix matches at one length: 64 results
  logic [PORT_W-1:0]    fan_port;
  logic [ADDR_BITS-1:0] fan_addr;
  logic [LEN_W-1:0]     fan_len;

  task automatic test_full_fanout();
    send_idle_pct = 29;
    recv_idle_pct = 76;
    fan_port = PORT_W'($urandom);
    fan_addr = $urandom;
    fan_len = LEN_W'($urandom_range(1, 31));
    for (int s = 0; s < NUM_SLOTS; s++)
      for (int j = 0; j < PORTS_PER; j++)
        send_beat(beat_of(ACT_WR_PORT, s, j, fan_port, $urandom, 0, 1));
    for (int s = 0; s < NUM_SLOTS; s++)
      for (int k = 0; k < PFX_PER; k++)
        send_beat(beat_of(ACT_WR_PREFIX, s, k, 16'h0,
                          (fan_addr & netmask(fan_len)) | ($urandom & ~netmask(fan_len)),
                          fan_len, 1));
    for (int i = 0; i < 3; i++)
      send_beat(beat_of(ACT_LOOKUP, 0, 0, fan_port,
                        (fan_addr & netmask(fan_len)) | ($urandom & ~netmask(fan_len)), 0, 0));
    // top bit flipped: outside every prefix
    send_beat(beat_of(ACT_LOOKUP, 0, 0, fan_port, fan_addr ^ 32'h8000_0000, 0, 0));
    wait_drained();
  endtask

  // Receiver stalls long while lookups keep coming, so the input backs up
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 6; i++)
      send_beat(beat_of(ACT_LOOKUP, $urandom_range(3), $urandom_range(7), fan_port,
                        (fan_addr & netmask(fan_len)) | ($urandom & ~netmask(fan_len)),
                        $urandom_range(63), 1'($urandom_range(1))));
    wait_drained();
  endtask

  function automatic void refresh_pools();
    port_pool[0] = PORT_W'($urandom);
    port_pool[1] = PORT_W'($urandom_range(15));
    port_pool[2] = PORT_W'(16'hFFFF - $urandom_range(3));
    addr_pool[0] = $urandom;
    addr_pool[1] = {8'd10, 24'($urandom)};
  endfunction

  // Mostly rule writes and lookups around a few ports and nets, some noise
  function automatic in_item_t random_beat();
    in_item_t b;
    int r;
    logic [ADDR_BITS-1:0] probe;
    logic [LEN_W-1:0] len;
    b.request_slot = RSLOT_W'($urandom_range(3));
    b.entry_slot = ESLOT_W'($urandom_range(7));
    b.port_value = PORT_W'($urandom);
    b.address = $urandom;
    b.prefix_length = LEN_W'($urandom_range(63));
    b.entry_valid = 1'($urandom_range(1));
    probe = addr_pool[$urandom_range(1)];
    r = $urandom_range(99);
    if (r < 20) begin
      b.action = ACT_WR_PORT;
      if ($urandom_range(9) != 0) b.entry_slot = ESLOT_W'($urandom_range(PORTS_PER - 1));
      if ($urandom_range(4) != 0) b.port_value = port_pool[$urandom_range(2)];
      if ($urandom_range(6) != 0) b.entry_valid = 1'b1;
    end else if (r < 55) begin
      b.action = ACT_WR_PREFIX;
      len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(63))
                                     : LEN_W'($urandom_range(32));
      b.prefix_length = len;
      if ($urandom_range(4) != 0)
        b.address = (probe & netmask(len)) | (b.address & ~netmask(len));
      if ($urandom_range(6) != 0) b.entry_valid = 1'b1;
    end else if (r < 95) begin
      b.action = ACT_LOOKUP;
      if ($urandom_range(99) < 85) b.port_value = port_pool[$urandom_range(2)];
      r = $urandom_range(99);
      if (r < 60) b.address = probe ^ ($urandom >> $urandom_range(31));
      else if (r < 85) b.address = probe;
    end else begin
      b.action = ACT_NONE;
    end
    return b;
  endfunction

  task automatic test_random(int beats, int s_pct, int r_pct);
    in_item_t b;
    int sent;
    sent = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    refresh_pools();
    while (sent < beats) begin
      if ($urandom_range(39) == 0) refresh_pools();
      b = random_beat();
      send_beat(b);
      if (b.action != ACT_NONE) sent++;
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_fanout();
    test_random(85, 29, 76);
    test_random(85, 76, 29);
    test_output_stall();
    test_random(70, 0, 0);

    repeat (DRAIN_CYC) @(posedge clk);
    $display("Ran %0d beats: %0d rule writes, %0d lookups (widest fan-out %0d).",
             n_beats, n_writes, n_lookups, widest_fanout);
    $display("Checked %0d acks, %0d matches, %0d no-matches; %0d mismatches, %0d still owed.",
             n_ack, n_match, n_nomatch, mismatches, lpm_results_due.size());
    if (mismatches == 0 && lpm_results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still owed", lpm_results_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
